>>> rtl/core/ffa_pkg.sv
// Shared types and constants of the first-fit boundary-tag allocator.
`default_nettype none
package ffa_pkg;

  // Byte offsets inside the sequencer; wide enough for wrapped tag arithmetic
  localparam int unsigned BW = 35;

  localparam int unsigned REQ_W   = 21;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned GROW_W  = 17;
  localparam int unsigned NEED_W  = 22;
  localparam int unsigned IN_TD_W = 48;
  localparam int unsigned OUT_TD_W = 24;

  localparam logic [GROW_W-1:0] GROW_RESET = 17'd4096;
  localparam logic [31:0] PAD_TAG  = 32'd0;
  localparam logic [31:0] PRO_TAG  = 32'd9;
  localparam logic [31:0] EPI_TAG  = 32'd1;
  localparam logic [BW-1:0] FIRST_BLOCK = 35'd8;
  localparam logic [BW-1:0] BREAK_RESET = 35'd16;
  localparam logic [BW-1:0] MIN_BLOCK = 35'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE,
    ST_WALK_RD, ST_WALK_CHK,
    ST_GROW, ST_GROW_W1, ST_GROW_W2,
    ST_FREE_HDR, ST_FREE_W1,
    ST_MRG_RD, ST_MRG_NXT, ST_MRG_PREF, ST_MRG_PREH, ST_MRG_PREV, ST_MRG_W0, ST_MRG_W1,
    ST_PL_RD, ST_PL_CHK, ST_PL_W0, ST_PL_W1, ST_PL_W2, ST_PL_W3,
    ST_DONE
  } state_e;

  // Command from the sequencer to the tag memory
  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] wdata;
  } mem_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/ffa_tag_ram.sv
// Single-port tag memory with registered read data.
`default_nettype none
module ffa_tag_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned IDX_W = 18
) (
  input  wire                    clk_i,
  input  wire ffa_pkg::mem_cmd_t cmd_i,
  input  wire [IDX_W-1:0]        idx_i,
  output logic [31:0]            rdata_o
);
  import ffa_pkg::*;

  logic [31:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      if (cmd_i.we) begin
        mem[idx_i] <= cmd_i.wdata;
      end else begin
        rdata_o <= mem[idx_i];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ffa_ctrl.sv
// Request sequencer: block walk, heap growth, coalescing and placement.
`default_nettype none
module ffa_ctrl #(
  parameter int unsigned HEAP_BYTES = 1048576,
  parameter int unsigned IDX_W = 18
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [ffa_pkg::GROW_W-1:0]     cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           in_op_i,
  input  wire [ffa_pkg::REQ_W-1:0]      in_req_size_i,
  input  wire [ffa_pkg::ADDR_W-1:0]     in_block_addr_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [ffa_pkg::ADDR_W-1:0]    out_addr_o,
  output logic                          out_ok_o,
  output ffa_pkg::mem_cmd_t             mem_cmd_o,
  output logic [IDX_W-1:0]              mem_idx_o,
  input  wire [31:0]                    mem_rdata_i
);
  import ffa_pkg::*;

  localparam logic [BW-1:0] HEAP_END = BW'(HEAP_BYTES);

  state_e              state_q, state_d;
  logic [BW-1:0]       p_q, p_d, sz_q, sz_d, pre_q, pre_d, brk_q, brk_d;
  logic [NEED_W-1:0]   need_q, need_d;
  logic                op_q, op_d, res_ok_q, res_ok_d, split_q, split_d;
  logic [1:0]          init_q, init_d;
  logic                oor_q;
  logic [GROW_W-1:0]   grow_q;
  logic                ov_q, ov_d, ook_q, ook_d;
  logic [ADDR_W-1:0]   oaddr_q, oaddr_d;

  logic                m_en, m_we, m_oor;
  logic [BW-1:0]       m_b;
  logic [31:0]         m_wd;
  logic [31:0]         rd;
  logic [BW-1:0]       rsz, chunk, nb, need_b, a_b;

  assign rd     = oor_q ? 32'd0 : mem_rdata_i;
  assign rsz    = BW'(rd & 32'hFFFF_FFF8);
  assign need_b = BW'(need_q);
  assign a_b    = BW'(in_block_addr_i);
  assign chunk  = (BW'(grow_q & 17'h1FFF8) < need_b) ? need_b : BW'(grow_q & 17'h1FFF8);
  assign nb     = brk_q + chunk;

  // Drop accesses outside the tag memory; those reads return zero
  assign m_oor            = (m_b >= HEAP_END);
  assign mem_cmd_o.en     = m_en && !m_oor;
  assign mem_cmd_o.we     = m_we;
  assign mem_cmd_o.wdata  = m_wd;
  assign mem_idx_o        = m_b[IDX_W+1:2];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_addr_o  = oaddr_q;
  assign out_ok_o    = ook_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      init_q   <= 2'd0;
      brk_q    <= BREAK_RESET;
      grow_q   <= GROW_RESET;
      ov_q     <= 1'b0;
      oor_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      brk_q    <= brk_d;
      ov_q     <= ov_d;
      oor_q    <= m_oor;
      if (cfg_we_i) begin
        grow_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    sz_q     <= sz_d;
    pre_q    <= pre_d;
    need_q   <= need_d;
    op_q     <= op_d;
    res_ok_q <= res_ok_d;
    split_q  <= split_d;
    ook_q    <= ook_d;
    oaddr_q  <= oaddr_d;
  end

  // Next state, memory command and result
  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    brk_d    = brk_q;
    p_d      = p_q;
    sz_d     = sz_q;
    pre_d    = pre_q;
    need_d   = need_q;
    op_d     = op_q;
    res_ok_d = res_ok_q;
    split_d  = split_q;
    ov_d     = ov_q && !out_ready_i;
    ook_d    = ook_q;
    oaddr_d  = oaddr_q;
    m_en     = 1'b0;
    m_we     = 1'b0;
    m_b      = p_q - BW'(4);
    m_wd     = 32'd0;
    case (state_q)
      ST_INIT: begin
        m_en = 1'b1;
        m_we = 1'b1;
        m_b  = BW'({init_q, 2'b00});
        case (init_q)
          2'd0:    m_wd = PAD_TAG;
          2'd3:    m_wd = EPI_TAG;
          default: m_wd = PRO_TAG;
        endcase
        init_d = init_q + 2'd1;
        if (init_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_op_i;
          res_ok_d = 1'b0;
          if (in_op_i == OP_ALLOC) begin
            need_d = (NEED_W'(in_req_size_i) + NEED_W'(15)) & ~NEED_W'(7);
            p_d    = FIRST_BLOCK;
            state_d = (in_req_size_i == '0) ? ST_DONE : ST_WALK_RD;
          end else begin
            p_d = a_b;
            if (in_block_addr_i[2:0] != 3'd0 || a_b < MIN_BLOCK || a_b >= brk_q) begin
              state_d = ST_DONE;
            end else begin
              m_en    = 1'b1;
              m_b     = a_b - BW'(4);
              state_d = ST_FREE_HDR;
            end
          end
        end
      end
      // First-fit walk, one header read per block
      ST_WALK_RD: begin
        if (p_q >= brk_q) begin
          state_d = ST_GROW;
        end else begin
          m_en    = 1'b1;
          state_d = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (rsz == '0) begin
          state_d = ST_GROW;
        end else if (!rd[0] && rsz >= need_b) begin
          state_d = ST_PL_RD;
        end else begin
          p_d     = p_q + rsz;
          state_d = ST_WALK_RD;
        end
      end
      // Extend the break and tag the new free block
      ST_GROW: begin
        if (nb > HEAP_END) begin
          state_d = ST_DONE;
        end else begin
          p_d     = brk_q;
          sz_d    = chunk;
          brk_d   = nb;
          m_en    = 1'b1;
          m_we    = 1'b1;
          m_b     = brk_q - BW'(4);
          m_wd    = chunk[31:0];
          state_d = ST_GROW_W1;
        end
      end
      ST_GROW_W1: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_b     = p_q + sz_q - BW'(8);
        m_wd    = sz_q[31:0];
        state_d = ST_GROW_W2;
      end
      ST_GROW_W2: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_b     = brk_q - BW'(4);
        m_wd    = EPI_TAG;
        state_d = ST_MRG_RD;
      end
      // Validate the header of the block to free and clear its tags
      ST_FREE_HDR: begin
        if (!rd[0] || rsz < MIN_BLOCK || p_q + rsz > brk_q) begin
          state_d = ST_DONE;
        end else begin
          sz_d    = rsz;
          m_en    = 1'b1;
          m_we    = 1'b1;
          m_wd    = rsz[31:0];
          state_d = ST_FREE_W1;
        end
      end
      ST_FREE_W1: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_b     = p_q + sz_q - BW'(8);
        m_wd    = sz_q[31:0];
        state_d = ST_MRG_RD;
      end
      // Coalesce with free neighbors
      ST_MRG_RD: begin
        m_en    = 1'b1;
        state_d = ST_MRG_NXT;
      end
      ST_MRG_NXT: begin
        sz_d    = rsz;
        m_en    = 1'b1;
        m_b     = p_q + rsz - BW'(4);
        state_d = ST_MRG_PREF;
      end
      ST_MRG_PREF: begin
        if (!rd[0]) begin
          sz_d = sz_q + rsz;
        end
        m_en    = 1'b1;
        m_b     = p_q - BW'(8);
        state_d = ST_MRG_PREH;
      end
      ST_MRG_PREH: begin
        pre_d   = p_q - rsz;
        m_en    = 1'b1;
        m_b     = p_q - rsz - BW'(4);
        state_d = ST_MRG_PREV;
      end
      ST_MRG_PREV: begin
        if (!rd[0]) begin
          sz_d = sz_q + rsz;
          p_d  = pre_q;
        end
        state_d = ST_MRG_W0;
      end
      ST_MRG_W0: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_wd    = sz_q[31:0] & 32'hFFFF_FFF8;
        state_d = ST_MRG_W1;
      end
      ST_MRG_W1: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_b     = p_q + sz_q - BW'(8);
        m_wd    = sz_q[31:0] & 32'hFFFF_FFF8;
        if (op_q == OP_ALLOC) begin
          state_d = ST_PL_RD;
        end else begin
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end
      end
      // Place: split the block or grant it whole
      ST_PL_RD: begin
        m_en    = 1'b1;
        state_d = ST_PL_CHK;
      end
      ST_PL_CHK: begin
        sz_d    = rsz;
        split_d = (rsz > need_b + BW'(8));
        state_d = ST_PL_W0;
      end
      ST_PL_W0: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_wd    = (split_q ? need_b[31:0] : sz_q[31:0]) | 32'd1;
        state_d = ST_PL_W1;
      end
      ST_PL_W1: begin
        m_en = 1'b1;
        m_we = 1'b1;
        m_b  = p_q + (split_q ? need_b : sz_q) - BW'(8);
        m_wd = (split_q ? need_b[31:0] : sz_q[31:0]) | 32'd1;
        if (split_q) begin
          state_d = ST_PL_W2;
        end else begin
          res_ok_d = 1'b1;
          state_d  = ST_DONE;
        end
      end
      ST_PL_W2: begin
        m_en    = 1'b1;
        m_we    = 1'b1;
        m_b     = p_q + need_b - BW'(4);
        m_wd    = sz_q[31:0] - need_b[31:0];
        state_d = ST_PL_W3;
      end
      ST_PL_W3: begin
        m_en     = 1'b1;
        m_we     = 1'b1;
        m_b      = p_q + sz_q - BW'(8);
        m_wd     = sz_q[31:0] - need_b[31:0];
        res_ok_d = 1'b1;
        state_d  = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ook_d   = res_ok_q;
          oaddr_d = (res_ok_q && op_q == OP_ALLOC) ? p_q[ADDR_W-1:0] : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/first_fit_boundary_tag_allocator_core.sv
// Allocation reads one header per block walked, then places and reports (more tag writes on a
//   split); growth adds a break check, tag writes and coalescing. Free also coalesces.
// Throughput: one request at a time; the single tag memory port serves one access per cycle.
// The next request is accepted while a result still waits in the output register.
// Reset: asynchronous, active low; the sequencer then writes the
//   padding, prologue and epilogue tags before it accepts a request.
`default_nettype none
module first_fit_boundary_tag_allocator_core #(
  parameter int unsigned HEAP_BYTES = 1048576
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [16:0] cfg_data_i,     // grow_chunk_bytes
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // req_size[20:0], block_addr[40:21], zero pad
  input  wire         s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // addr[19:0], ok[20], zero pad
);
  import ffa_pkg::*;

  localparam int unsigned DEPTH = HEAP_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  mem_cmd_t          mem_cmd;
  logic [IDX_W-1:0]  mem_idx;
  logic [31:0]       mem_rdata;
  logic [ADDR_W-1:0] out_addr;
  logic              out_ok;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {3'b000, out_ok, out_addr};

  ffa_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser),
    .in_req_size_i  (s_axis_tdata[20:0]),
    .in_block_addr_i(s_axis_tdata[40:21]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_addr_o     (out_addr),
    .out_ok_o       (out_ok),
    .mem_cmd_o      (mem_cmd),
    .mem_idx_o      (mem_idx),
    .mem_rdata_i    (mem_rdata)
  );

  ffa_tag_ram #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .cmd_i  (mem_cmd),
    .idx_i  (mem_idx),
    .rdata_o(mem_rdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/ffa_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`default_nettype none
module ffa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [23:0] m_axis_tdata
);

  // A stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A failed request grants no block
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[20] |-> m_axis_tdata[19:0] == 20'd0)
    else $error("failed request carries an address");

  // Granted payloads are 8-byte aligned
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("granted address not aligned");

  // One request at a time: the input stalls right after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");

endmodule

bind first_fit_boundary_tag_allocator_core ffa_checker u_ffa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the first-fit boundary-tag heap allocator core.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned HEAP = 1048576;
  localparam int unsigned TAG_WORDS = HEAP / 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  first_fit_boundary_tag_allocator_core #(.HEAP_BYTES(HEAP)) dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Heap mirror: tag words, break and growth chunk
  bit [31:0]       tag_mem[int unsigned];
  longint unsigned heap_brk;
  longint unsigned grow_chunk;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              ok;
  } grant_t;

  grant_t          grants_due[$];
  int unsigned     live_ptrs[$];
  int              errors = 0;

  function automatic longint unsigned tag_rd(longint unsigned b);
    longint unsigned i;
    i = b / 4;
    if (i < TAG_WORDS && tag_mem.exists(int'(i))) return tag_mem[int'(i)];
    return 0;
  endfunction

  function automatic void tag_wr(longint unsigned b, longint unsigned v);
    longint unsigned i;
    i = b / 4;
    if (i < TAG_WORDS) tag_mem[int'(i)] = v[31:0];
  endfunction

  function automatic longint unsigned blk_size(longint unsigned p);
    return tag_rd(p - 4) & 64'hFFFF_FFF8;
  endfunction

  function automatic bit blk_used(longint unsigned p);
    return (tag_rd(p - 4) & 1) != 0;
  endfunction

  function automatic void write_tags(longint unsigned p, longint unsigned sz, bit a);
    tag_wr(p - 4, (sz & 64'hFFFF_FFF8) | a);
    tag_wr(p + sz - 8, (sz & 64'hFFFF_FFF8) | a);
  endfunction

  function automatic longint unsigned coalesce(longint unsigned p);
    longint unsigned nxt, pre, sz;
    nxt = p + blk_size(p);
    pre = p - (tag_rd(p - 8) & 64'hFFFF_FFF8);
    sz = blk_size(p);
    if (!blk_used(nxt)) sz += blk_size(nxt);
    if (!blk_used(pre)) begin
      sz += blk_size(pre);
      p = pre;
    end
    write_tags(p, sz, 1'b0);
    return p;
  endfunction

  function automatic void carve(longint unsigned p, longint unsigned need);
    longint unsigned sz;
    sz = blk_size(p);
    if (sz <= need + 8) begin
      write_tags(p, sz, 1'b1);
    end else begin
      write_tags(p, need, 1'b1);
      write_tags(p + need, sz - need, 1'b0);
    end
  endfunction

  function automatic void heap_init();
    tag_mem.delete();
    tag_wr(0, 0);
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    heap_brk = 16;
    grow_chunk = 4096;
  endfunction

  // Expected grant for one request; updates the mirror
  function automatic grant_t heap_grant(logic op, logic [REQ_W-1:0] req,
                                        logic [ADDR_W-1:0] baddr);
    grant_t g;
    longint unsigned need, p, sz, chunk, nb, a;
    g = '0;
    if (op == OP_ALLOC) begin
      if (req == 0) return g;
      need = (longint'(req) + 15) & ~64'd7;
      p = 8;
      while (p < heap_brk) begin
        sz = blk_size(p);
        if (sz == 0) break;
        if (!blk_used(p) && sz >= need) begin
          carve(p, need);
          g.addr = p[ADDR_W-1:0];
          g.ok = 1'b1;
          return g;
        end
        p += sz;
      end
      chunk = grow_chunk & ~64'd7;
      if (chunk < need) chunk = need;
      nb = heap_brk + chunk;
      if (nb > HEAP) return g;
      p = heap_brk;
      heap_brk = nb;
      write_tags(p, chunk, 1'b0);
      tag_wr(nb - 4, 1);
      p = coalesce(p);
      carve(p, need);
      g.addr = p[ADDR_W-1:0];
      g.ok = 1'b1;
    end else begin
      a = baddr;
      if ((a & 7) != 0 || a < 16 || a >= heap_brk) return g;
      if (!blk_used(a)) return g;
      sz = blk_size(a);
      if (sz < 16 || a + sz > heap_brk) return g;
      write_tags(a, sz, 1'b0);
      void'(coalesce(a));
      g.ok = 1'b1;
    end
    return g;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one request beat and record its expected grant on acceptance
  task automatic send_req(logic op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] baddr,
                          bit random_gap);
    grant_t g;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, baddr, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    g = heap_grant(op, req, baddr);
    grants_due.push_back(g);
    if (op == OP_ALLOC && g.ok) live_ptrs.push_back(g.addr);
    gap = random_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_chunk(logic [GROW_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    grow_chunk = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic free_live(int idx);
    int unsigned a;
    a = live_ptrs[idx];
    live_ptrs.delete(idx);
    send_req(OP_FREE, REQ_W'($urandom), a[ADDR_W-1:0], 1'b1);
  endtask

  task automatic free_all();
    while (live_ptrs.size() != 0) free_live($urandom_range(0, live_ptrs.size() - 1));
  endtask

  // Output-side stalls: random, with quiet stretches
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;
  always @(posedge clk_i) begin
    if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 99) < 3) quiet_left <= $urandom_range(50, 400);
      else stall_left <= pick_gap();
    end
  end

  // Compare each result beat with the oldest expected grant
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (m_axis_tdata[19:0] !== want.addr) begin
          $display("%0t: addr expected %h actual %h", $realtime, want.addr,
                   m_axis_tdata[19:0]);
          errors++;
        end
        if (m_axis_tdata[20] !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $realtime, want.ok, m_axis_tdata[20]);
          errors++;
        end
        if (m_axis_tdata[23:21] !== 3'd0) begin
          $display("%0t: pad expected 0 actual %h", $realtime, m_axis_tdata[23:21]);
          errors++;
        end
      end
    end
  end

  task automatic test_edge_requests();
    send_req(OP_ALLOC, 21'd0, 20'hFFFFF, 1'b0);
    send_req(OP_ALLOC, 21'd1, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd8, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd9, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd1048576, 20'd0, 1'b1);
    send_req(OP_ALLOC, 21'd1048560, 20'd0, 1'b1);
    send_req(OP_FREE, 21'h1FFFFF, 20'd13, 1'b0);
    send_req(OP_FREE, 21'd0, 20'd0, 1'b0);
    send_req(OP_FREE, 21'd0, 20'd8, 1'b0);
    send_req(OP_FREE, 21'd0, 20'hFFFF8, 1'b0);
    send_req(OP_FREE, 21'd0, 20'hFFFFF, 1'b0);
  endtask

  // Free with no free neighbor, with a free left and with both free neighbors
  task automatic test_coalescing();
    int unsigned a, b, c, d;
    send_req(OP_ALLOC, 21'd40, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd40, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd40, 20'd0, 1'b0);
    send_req(OP_ALLOC, 21'd40, 20'd0, 1'b0);
    d = live_ptrs.pop_back();
    c = live_ptrs.pop_back();
    b = live_ptrs.pop_back();
    a = live_ptrs.pop_back();
    send_req(OP_FREE, 21'd0, a[19:0], 1'b0);
    send_req(OP_FREE, 21'd0, c[19:0], 1'b0);
    send_req(OP_FREE, 21'd0, b[19:0], 1'b0);
    send_req(OP_FREE, 21'd0, b[19:0], 1'b0);
    send_req(OP_ALLOC, 21'd140, 20'd0, 1'b0);
    send_req(OP_FREE, 21'd0, d[19:0], 1'b0);
    free_all();
  endtask

  task automatic test_growth_extremes();
    write_chunk(17'd8);
    send_req(OP_ALLOC, 21'd5000, 20'd0, 1'b1);
    send_req(OP_ALLOC, 21'd1, 20'd0, 1'b1);
    free_all();
    write_chunk(17'd65536);
    repeat (17) send_req(OP_ALLOC, 21'd60000, 20'd0, 1'b1);
    free_all();
    write_chunk(17'd65535);
    send_req(OP_ALLOC, 21'd100, 20'd0, 1'b1);
    free_all();
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned r;
    int unsigned a;
    logic [REQ_W-1:0] sz;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // malformed free: misaligned, too low or past the break
        case ($urandom_range(0, 2))
          0: a = $urandom | 1;
          1: a = $urandom_range(0, 1) * 8;
          default: a = (heap_brk < HEAP) ?
                       ($urandom_range(32'(heap_brk / 8), HEAP / 8 - 1) * 8) : 20'hFFFFF;
        endcase
        send_req(OP_FREE, REQ_W'($urandom), a[19:0], 1'b1);
      end else if (live_ptrs.size() != 0 &&
                   r < (live_ptrs.size() > 40 ? 75 : 45)) begin
        free_live($urandom_range(0, live_ptrs.size() - 1));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) sz = REQ_W'($urandom_range(1, 256));
        else if (r < 90) sz = REQ_W'($urandom_range(257, 4096));
        else if (r < 97) sz = REQ_W'($urandom_range(4097, 65536));
        else if (r < 98) sz = 21'd0;
        else if (r < 99) sz = 21'd1048576;
        else sz = REQ_W'($urandom_range(65537, 1048576));
        send_req(OP_ALLOC, sz, ADDR_W'($urandom), 1'b1);
      end
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  task automatic test_random_traffic();
    write_chunk(17'd4096);
    random_phase(300);
    write_chunk(17'd8);
    random_phase(250);
    write_chunk(17'd65536);
    random_phase(200);
    write_chunk(GROW_W'({13'($urandom_range(1, 8191)), 3'($urandom)}));
    random_phase(250);
  endtask

  initial begin
    heap_init();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_edge_requests();
    test_coalescing();
    test_growth_extremes();
    test_random_traffic();
    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/core/ffa_pkg.sv
rtl/core/ffa_tag_ram.sv
rtl/core/ffa_ctrl.sv
rtl/core/first_fit_boundary_tag_allocator_core.sv
rtl/core/ffa_checker.sv
tb/tb_top.sv
